>>> src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`endif

>>> src/fted_pkg.sv
// Shared constants, types and helper function of the fuzzy term matcher.
`default_nettype none

package fted_pkg;

   localparam int MAX_LEN   = 32;
   localparam int CHAR_BITS = 16;
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int IDX_W     = $clog2(MAX_LEN);
   localparam int THR_W     = 16;

   localparam logic [THR_W-1:0] THR_RESET = 16'h8000;

   localparam logic ACT_QUERY = 1'b0;
   localparam logic ACT_CAND  = 1'b1;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   // One candidate character travelling down the row of cells.
   typedef struct packed {
      logic                 valid;
      logic                 fresh;
      logic [CHAR_BITS-1:0] char_code;
      logic [LEN_W-1:0]     up;
      logic [LEN_W-1:0]     diag;
   } token_type;

   typedef struct packed {
      logic [LEN_W-1:0] edit_distance;
      logic             is_match;
      logic             end_of_field;
      logic             too_long;
   } result_type;

   typedef logic [MAX_LEN-1:0][LEN_W-1:0] cols_type;

   function automatic logic [LEN_W-1:0] min3(input logic [LEN_W-1:0] a,
                                             input logic [LEN_W-1:0] b,
                                             input logic [LEN_W-1:0] c);
      logic [LEN_W-1:0] t;
      t = (a < b) ? a : b;
      return (t < c) ? t : c;
   endfunction

endpackage

`default_nettype wire

>>> src/fted_cell.sv
// One column cell of the Levenshtein row: query character and column distance.
`default_nettype none

module fted_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           wr_en,
   input  wire logic [fted_pkg::CHAR_BITS-1:0] wr_char,
   input  wire logic [fted_pkg::LEN_W-1:0]     col_index,
   input  wire fted_pkg::token_type            tok_in,
   output fted_pkg::token_type                 tok_out,
   output logic [fted_pkg::LEN_W-1:0]          col_value
);

   logic [fted_pkg::CHAR_BITS-1:0] q_ff;
   logic [fted_pkg::LEN_W-1:0]     dist_ff;
   logic [fted_pkg::LEN_W-1:0]     dist_in;
   logic [fted_pkg::LEN_W-1:0]     left;
   fted_pkg::token_type            tok_ff;
   fted_pkg::token_type            tok_in_next;

   always_comb begin
      // A fresh token sees the row as just reset: this column holds its own index.
      left = tok_in.fresh ? col_index : dist_ff;
      if (q_ff != tok_in.char_code) begin
         dist_in = fted_pkg::min3(tok_in.up, left, tok_in.diag) + 1'b1;
      end else begin
         dist_in = fted_pkg::min3(tok_in.up + 1'b1, left + 1'b1, tok_in.diag);
      end
      tok_in_next.valid     = tok_in.valid;
      tok_in_next.fresh     = tok_in.fresh;
      tok_in_next.char_code = tok_in.char_code;
      tok_in_next.up        = dist_in;
      tok_in_next.diag      = left;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff <= wr_char;
      end
      if (tok_in.valid) begin
         dist_ff <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out   = tok_ff;
   assign col_value = dist_ff;

endmodule

`default_nettype wire

>>> src/fted_score.sv
// Final distance selection and the division-free similarity threshold test.
`default_nettype none

module fted_score (
   input  wire fted_pkg::cols_type             cols,
   input  wire logic [fted_pkg::LEN_W-1:0]     qlen,
   input  wire logic [fted_pkg::LEN_W-1:0]     clen,
   input  wire logic                           feq,
   input  wire logic                           ovf,
   input  wire logic [fted_pkg::THR_W-1:0]     thr,
   output fted_pkg::result_type                result
);

   logic [fted_pkg::LEN_W-1:0]             dist_sel;
   logic [fted_pkg::LEN_W-1:0]             mn;
   logic [fted_pkg::LEN_W-1:0]             qlen_m1;
   logic [fted_pkg::THR_W:0]               headroom;
   logic [fted_pkg::THR_W+fted_pkg::LEN_W:0] lhs;
   logic [fted_pkg::THR_W+fted_pkg::LEN_W:0] rhs;

   always_comb begin
      qlen_m1 = qlen - 1'b1;
      // An empty string on either side leaves the other length as the distance.
      if (qlen == '0) begin
         dist_sel = clen;
      end else if (clen == '0) begin
         dist_sel = qlen;
      end else begin
         dist_sel = cols[qlen_m1[fted_pkg::IDX_W-1:0]];
      end
      mn       = (qlen < clen) ? qlen : clen;
      headroom = {1'b1, {fted_pkg::THR_W{1'b0}}} - {1'b0, thr};
      lhs      = {1'b0, dist_sel, {fted_pkg::THR_W{1'b0}}};
      rhs      = headroom * mn;

      result.edit_distance = feq ? dist_sel : '0;
      result.is_match      = feq && (qlen != '0) && (clen != '0) && (lhs < rhs);
      result.end_of_field  = !feq;
      result.too_long      = ovf;
   end

endmodule

`default_nettype wire

>>> src/fuzzy_term_edit_distance_match.sv
// Top level of the fuzzy term matcher: control, row of column cells and scoring.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   request  | start / busy           | req_action, req_char_code, req_char_valid,
//            |                        | req_last_char, req_field_equal
//   result   | rsp_valid (one cycle)  | rsp_edit_distance, rsp_is_match,
//            |                        | rsp_end_of_field, rsp_too_long
//   config   | csr_valid / csr_ready  | csr_similarity_threshold
//
// Query and candidate characters are taken one per cycle while busy is low;
// candidate characters flow down the row of cells, one column per cycle.
// After a candidate's last request, busy stays high while the last character
// reaches the query's final column; then rsp_valid pulses for one cycle.
// Reset is synchronous; csr_ready is always high.
// The result side cannot stall, so results are never held.
`default_nettype none

module fuzzy_term_edit_distance_match (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_action,
   input  wire logic [15:0]                    req_char_code,
   input  wire logic                           req_char_valid,
   input  wire logic                           req_last_char,
   input  wire logic                           req_field_equal,
   output logic                                rsp_valid,
   output logic [5:0]                          rsp_edit_distance,
   output logic                                rsp_is_match,
   output logic                                rsp_end_of_field,
   output logic                                rsp_too_long,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [15:0]                    csr_similarity_threshold
);

   localparam int LW = fted_pkg::LEN_W;

   logic [LW-1:0]              qlen_ff, qlen_in;
   logic                       qovf_ff, qovf_in;
   logic                       qclosed_ff, qclosed_in;
   logic [LW-1:0]              clen_ff, clen_in;
   logic                       covf_ff, covf_in;
   logic                       copen_ff, copen_in;
   logic                       fresh_ff, fresh_in;
   logic                       feq_ff, feq_in;
   logic                       state_ff, state_in;
   logic [LW-1:0]              cnt_ff, cnt_in;
   logic [fted_pkg::THR_W-1:0] thr_ff, thr_in;
   fted_pkg::token_type        tok0_ff, tok0_in;
   fted_pkg::result_type       rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [fted_pkg::MAX_LEN-1:0] qwr_en;
   logic                         accept;
   logic [LW-1:0]                qlen_eff, clen_eff;
   logic                         fresh_eff;

   fted_pkg::token_type  tok [fted_pkg::MAX_LEN+1];
   fted_pkg::cols_type   cols;
   fted_pkg::result_type score;

   assign busy      = (state_ff != fted_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_comb begin
      qlen_in      = qlen_ff;
      qovf_in      = qovf_ff;
      qclosed_in   = qclosed_ff;
      clen_in      = clen_ff;
      covf_in      = covf_ff;
      copen_in     = copen_ff;
      fresh_in     = fresh_ff;
      feq_in       = feq_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      thr_in       = (csr_valid && csr_ready) ? csr_similarity_threshold : thr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      qwr_en       = '0;
      qlen_eff     = qclosed_ff ? '0 : qlen_ff;
      clen_eff     = copen_ff ? clen_ff : '0;
      fresh_eff    = copen_ff ? fresh_ff : 1'b1;

      tok0_in.valid     = 1'b0;
      tok0_in.fresh     = fresh_eff;
      tok0_in.char_code = req_char_code;
      tok0_in.up        = clen_eff + 1'b1;
      tok0_in.diag      = clen_eff;

      if (accept && (req_action == fted_pkg::ACT_QUERY)) begin
         // A query request closes any open candidate without a result.
         copen_in   = 1'b0;
         qclosed_in = req_last_char;
         qlen_in    = qlen_eff;
         qovf_in    = qclosed_ff ? 1'b0 : qovf_ff;
         if (req_char_valid) begin
            if (qlen_eff < LW'(fted_pkg::MAX_LEN)) begin
               qwr_en[qlen_eff[fted_pkg::IDX_W-1:0]] = 1'b1;
               qlen_in = qlen_eff + 1'b1;
            end else begin
               qovf_in = 1'b1;
            end
         end
      end else if (accept) begin
         qclosed_in = 1'b1;
         copen_in   = !req_last_char;
         clen_in    = clen_eff;
         covf_in    = copen_ff ? covf_ff : 1'b0;
         fresh_in   = fresh_eff;
         if (req_char_valid) begin
            if (clen_eff < LW'(fted_pkg::MAX_LEN)) begin
               tok0_in.valid = 1'b1;
               clen_in       = clen_eff + 1'b1;
               fresh_in      = 1'b0;
            end else begin
               covf_in = 1'b1;
            end
         end
         if (req_last_char) begin
            feq_in   = req_field_equal;
            state_in = fted_pkg::ST_DRAIN;
            cnt_in   = qlen_ff;
         end
      end

      if (state_ff == fted_pkg::ST_DRAIN) begin
         if (cnt_ff == '0) begin
            rsp_in       = score;
            rsp_valid_in = 1'b1;
            state_in     = fted_pkg::ST_IDLE;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff      <= '0;
         qovf_ff      <= 1'b0;
         qclosed_ff   <= 1'b1;
         clen_ff      <= '0;
         covf_ff      <= 1'b0;
         copen_ff     <= 1'b0;
         fresh_ff     <= 1'b1;
         state_ff     <= fted_pkg::ST_IDLE;
         cnt_ff       <= '0;
         thr_ff       <= fted_pkg::THR_RESET;
         tok0_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         qlen_ff      <= qlen_in;
         qovf_ff      <= qovf_in;
         qclosed_ff   <= qclosed_in;
         clen_ff      <= clen_in;
         covf_ff      <= covf_in;
         copen_ff     <= copen_in;
         fresh_ff     <= fresh_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         thr_ff       <= thr_in;
         tok0_ff      <= tok0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      feq_ff <= feq_in;
      rsp_ff <= rsp_in;
   end

   assign tok[0] = tok0_ff;

   for (genvar k = 0; k < fted_pkg::MAX_LEN; k++) begin : g_cell
      fted_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (qwr_en[k]),
         .wr_char   (req_char_code),
         .col_index (LW'(k + 1)),
         .tok_in    (tok[k]),
         .tok_out   (tok[k+1]),
         .col_value (cols[k])
      );
   end

   fted_score u_score (
      .cols   (cols),
      .qlen   (qlen_ff),
      .clen   (clen_ff),
      .feq    (feq_ff),
      .ovf    (qovf_ff || covf_ff),
      .thr    (thr_ff),
      .result (score)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_edit_distance = rsp_ff.edit_distance;
   assign rsp_is_match      = rsp_ff.is_match;
   assign rsp_end_of_field  = rsp_ff.end_of_field;
   assign rsp_too_long      = rsp_ff.too_long;

endmodule

`default_nettype wire

>>> src/fted_checker.sv
// Port-level checks of the fuzzy term matcher, bound to its top level.
`default_nettype none

`include "assert_macros.svh"

module fted_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_action,
   input  wire logic        req_last_char,
   input  wire logic        rsp_valid,
   input  wire logic [5:0]  rsp_edit_distance,
   input  wire logic        rsp_is_match,
   input  wire logic        rsp_end_of_field
);

   logic last_cand_req;

   assign last_cand_req = start && !busy && (req_action == fted_pkg::ACT_CAND) && req_last_char;

   // A candidate's last request always starts the wait for its result.
   `ASSERT_NEXT(a_last_sets_busy, clock, reset, last_cand_req, busy)
   // The result shows when the row has drained, and results never come back to back.
   `ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // A field mismatch reports no distance and no match.
   `ASSERT_SAME(a_field_end, clock, reset, rsp_valid && rsp_end_of_field,
                (rsp_edit_distance == 6'd0) && !rsp_is_match)
   `ASSERT_SAME(a_dist_range, clock, reset, rsp_valid, rsp_edit_distance <= 6'd32)

endmodule

bind fuzzy_term_edit_distance_match fted_checker u_fted_checker (.*);

`default_nettype wire
